// File: hw/rtl/sector_connected_component_labeler_unit_defines.svh
// Assertion macros shared by the labeler RTL.
`ifndef SECTOR_CONNECTED_COMPONENT_LABELER_UNIT_DEFINES_SVH
`define SECTOR_CONNECTED_COMPONENT_LABELER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCCLU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SCCLU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/scclu_pkg.sv
// Shared types, constants and datapath command codes for the sector labeler.
package scclu_pkg;

	localparam int ZONE_BITS    = 20;
	localparam int LABEL_W      = 2;
	localparam int DIM_W        = 4;
	localparam int MAX_SIDE_DEF = 8;
	localparam int SIDE_RESET   = 8;

	// register index of sector_side (paddr[2])
	localparam logic [0:0] REG_SECTOR_SIDE = 1'b0;

	typedef struct packed {
		logic [LABEL_W-1:0] class_code;
		logic [DIM_W-1:0]   cols_in_use;
		logic [DIM_W-1:0]   rows_in_use;
		logic               first_sector;
	} item_t;

	typedef struct packed {
		logic [ZONE_BITS-1:0] zone_number;
		logic                 last_of_sector;
	} result_t;

	// datapath commands
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_ULK,
		OP_ULN,
		OP_UCMP,
		OP_FIND_A,
		OP_FIND_B,
		OP_ADV,
		OP_ORDP,
		OP_ORDZ,
		OP_OEMIT
	} op_t;

	// datapath status back to the controller
	typedef struct packed {
		logic closes;
		logic init_last;
		logic edge_ok;
		logic lab_eq;
		logic hit;
		logic un_last;
		logic is_root;
		logic out_last;
	} status_t;

endpackage

// File: hw/rtl/scclu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scclu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/scclu_ctrl.sv
// Sequencer: load, parent init, union pass, zone output pass.
module scclu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  scclu_pkg::status_t status,
	output logic              busy,
	output scclu_pkg::op_t    op
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_ULK,
		S_ULN,
		S_UCMP,
		S_FIND_A,
		S_FIND_B,
		S_ORDP,
		S_ORDZ,
		S_OEMIT
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		op      = scclu_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op = scclu_pkg::OP_LOAD;
					if (status.closes) state_d = S_INIT;
				end
			end
			S_INIT: begin
				op = scclu_pkg::OP_INIT;
				if (status.init_last) state_d = S_ULK;
			end
			S_ULK: begin
				if (status.edge_ok) begin
					op      = scclu_pkg::OP_ULK;
					state_d = S_ULN;
				end else begin
					op = scclu_pkg::OP_ADV;
					if (status.un_last) state_d = S_ORDP;
				end
			end
			S_ULN: begin
				op      = scclu_pkg::OP_ULN;
				state_d = S_UCMP;
			end
			S_UCMP: begin
				if (status.lab_eq) begin
					op      = scclu_pkg::OP_UCMP;
					state_d = S_FIND_A;
				end else begin
					op      = scclu_pkg::OP_ADV;
					state_d = status.un_last ? S_ORDP : S_ULK;
				end
			end
			S_FIND_A: begin
				op = scclu_pkg::OP_FIND_A;
				if (status.hit) state_d = S_FIND_B;
			end
			S_FIND_B: begin
				op = scclu_pkg::OP_FIND_B;
				if (status.hit) state_d = status.un_last ? S_ORDP : S_ULK;
			end
			S_ORDP: begin
				op      = scclu_pkg::OP_ORDP;
				state_d = S_ORDZ;
			end
			S_ORDZ: begin
				op = scclu_pkg::OP_ORDZ;
				if (status.is_root) state_d = status.out_last ? S_IDLE : S_ORDP;
				else                state_d = S_OEMIT;
			end
			S_OEMIT: begin
				op      = scclu_pkg::OP_OEMIT;
				state_d = status.out_last ? S_IDLE : S_ORDP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// File: hw/rtl/scclu_dp.sv
// Datapath: label/parent/zone stores, counters, find chase and zone numbering.
module scclu_dp #(
	parameter int MAX_SIDE = scclu_pkg::MAX_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scclu_pkg::op_t                op,
	input  scclu_pkg::item_t              item,
	input  logic [scclu_pkg::DIM_W-1:0]   side_cfg,
	output scclu_pkg::status_t            status,
	output scclu_pkg::result_t            result,
	output logic                          result_strobe
);

	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int ZB    = scclu_pkg::ZONE_BITS;
	localparam int LW    = scclu_pkg::LABEL_W;
	localparam int DW    = scclu_pkg::DIM_W;

	function automatic logic [SW-1:0] clamp_dim(input logic [DW-1:0] v,
		input logic [SW-1:0] hi);
		if (v == '0) return SW'(1);
		else if (v > DW'(hi)) return hi;
		else return v[SW-1:0];
	endfunction

	// geometry of the incoming beat
	logic [SW-1:0]   side, cols_in, rows_in;
	logic [2*SW-1:0] prod;
	logic [CW-1:0]   total_in, cnt_inc;

	assign side     = clamp_dim(side_cfg, SW'(MAX_SIDE));
	assign cols_in  = clamp_dim(item.cols_in_use, side);
	assign rows_in  = clamp_dim(item.rows_in_use, side);
	assign prod     = cols_in * rows_in;
	assign total_in = prod[CW-1:0];

	logic [CW-1:0] load_cnt_q;
	logic [ZB-1:0] zone_cnt_q;
	logic          strobe_q;

	logic [SW-1:0] cols_q, rows_q, r_q, c_q;
	logic [CW-1:0] total_q;
	logic [AW-1:0] k_q, x_q, ra_q;
	logic          e_q;
	logic [LW-1:0] lab_k_q;
	scclu_pkg::result_t res_q;

	assign cnt_inc = load_cnt_q + CW'(1);

	// RAM ports
	logic [LW-1:0] lab_rd;
	logic [AW-1:0] lab_raddr;
	logic          par_we;
	logic [AW-1:0] par_waddr, par_wdata, par_raddr, par_rd;
	logic          zone_we;
	logic [ZB-1:0] zone_wdata, zone_rd;

	// scan position helpers
	logic          last_k, c_last, hit, is_root, emit;
	logic [AW-1:0] nbr;

	assign last_k  = (CW'(k_q) + CW'(1)) == total_q;
	assign c_last  = (c_q + SW'(1)) == cols_q;
	assign nbr     = e_q ? (k_q - AW'(cols_q)) : (k_q - AW'(1));
	assign hit     = (par_rd == x_q);
	assign is_root = (par_rd == k_q);
	assign emit    = (op == scclu_pkg::OP_OEMIT) || ((op == scclu_pkg::OP_ORDZ) && is_root);

	assign status.closes    = (cnt_inc >= total_in);
	assign status.init_last = last_k;
	assign status.edge_ok   = e_q ? (r_q != '0) : (c_q != '0);
	assign status.lab_eq    = (lab_k_q == lab_rd);
	assign status.hit       = hit;
	assign status.un_last   = e_q && last_k;
	assign status.is_root   = is_root;
	assign status.out_last  = last_k;

	// advance to the next (cell, edge) of the union pass
	logic [AW-1:0] k_nx;
	logic [SW-1:0] r_nx, c_nx;
	logic          e_nx;

	always_comb begin
		e_nx = ~e_q;
		k_nx = k_q;
		r_nx = r_q;
		c_nx = c_q;
		if (e_q) begin
			k_nx = last_k ? '0 : k_q + AW'(1);
			if (c_last) begin
				c_nx = '0;
				r_nx = r_q + SW'(1);
			end else begin
				c_nx = c_q + SW'(1);
			end
		end
	end

	// label read address: neighbour on ULN, else current cell
	assign lab_raddr = (op == scclu_pkg::OP_ULN) ? nbr : k_q;

	// parent port: init writes k->k, link writes larger root to smaller
	always_comb begin
		par_we    = 1'b0;
		par_waddr = k_q;
		par_wdata = k_q;
		par_raddr = k_q;
		case (op)
			scclu_pkg::OP_INIT: begin
				par_we = 1'b1;
			end
			scclu_pkg::OP_FIND_A: begin
				par_raddr = hit ? nbr : par_rd;
			end
			scclu_pkg::OP_FIND_B: begin
				par_raddr = par_rd;
				if (hit && (ra_q != x_q)) begin
					par_we    = 1'b1;
					par_waddr = (ra_q > x_q) ? ra_q : x_q;
					par_wdata = (ra_q > x_q) ? x_q : ra_q;
				end
			end
			default: begin
			end
		endcase
	end

	// zone of a cell: fresh counter value at a root, else its parent's zone
	assign zone_we    = emit;
	assign zone_wdata = (op == scclu_pkg::OP_OEMIT) ? zone_rd : zone_cnt_q;

	scclu_ram #(.WIDTH(LW), .DEPTH(CELLS)) u_label_ram (
		.clk  (clk),
		.we   (op == scclu_pkg::OP_LOAD),
		.waddr(load_cnt_q[AW-1:0]),
		.wdata(item.class_code),
		.raddr(lab_raddr),
		.rdata(lab_rd)
	);

	scclu_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_parent_ram (
		.clk  (clk),
		.we   (par_we),
		.waddr(par_waddr),
		.wdata(par_wdata),
		.raddr(par_raddr),
		.rdata(par_rd)
	);

	scclu_ram #(.WIDTH(ZB), .DEPTH(CELLS)) u_zone_ram (
		.clk  (clk),
		.we   (zone_we),
		.waddr(k_q),
		.wdata(zone_wdata),
		.raddr(par_rd),
		.rdata(zone_rd)
	);

	// load count, zone counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			zone_cnt_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (op == scclu_pkg::OP_LOAD) begin
				if ((load_cnt_q == '0) && item.first_sector) zone_cnt_q <= '0;
				load_cnt_q <= status.closes ? '0 : cnt_inc;
			end
			if ((op == scclu_pkg::OP_ORDZ) && is_root && (zone_cnt_q != '1)) begin
				zone_cnt_q <= zone_cnt_q + ZB'(1);
			end
		end
	end

	// scan counters, find registers and result payload
	always_ff @(posedge clk) begin
		case (op)
			scclu_pkg::OP_LOAD: begin
				cols_q  <= cols_in;
				rows_q  <= rows_in;
				total_q <= total_in;
				k_q     <= '0;
			end
			scclu_pkg::OP_INIT: begin
				if (last_k) begin
					k_q <= '0;
					r_q <= '0;
					c_q <= '0;
					e_q <= 1'b0;
				end else begin
					k_q <= k_q + AW'(1);
				end
			end
			scclu_pkg::OP_ULN: begin
				lab_k_q <= lab_rd;
			end
			scclu_pkg::OP_UCMP: begin
				x_q <= k_q;
			end
			scclu_pkg::OP_FIND_A: begin
				if (hit) begin
					ra_q <= x_q;
					x_q  <= nbr;
				end else begin
					x_q <= par_rd;
				end
			end
			scclu_pkg::OP_FIND_B: begin
				if (hit) begin
					k_q <= k_nx;
					r_q <= r_nx;
					c_q <= c_nx;
					e_q <= e_nx;
				end else begin
					x_q <= par_rd;
				end
			end
			scclu_pkg::OP_ADV: begin
				k_q <= k_nx;
				r_q <= r_nx;
				c_q <= c_nx;
				e_q <= e_nx;
			end
			scclu_pkg::OP_ORDZ: begin
				if (is_root) begin
					res_q.zone_number    <= zone_cnt_q;
					res_q.last_of_sector <= last_k;
					k_q                  <= k_q + AW'(1);
				end
			end
			scclu_pkg::OP_OEMIT: begin
				res_q.zone_number    <= zone_rd;
				res_q.last_of_sector <= last_k;
				k_q                  <= k_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

// File: hw/rtl/sector_connected_component_labeler_unit.sv
// Top level of the sector connected-component labeler: APB register, controller, datapath.
//
// channel   | handshake                          | payload
// ----------+------------------------------------+-------------------------------
// cells in  | start & !busy                      | item (label, cols, rows, first)
// zones out | result_strobe, one cycle per beat  | result (zone_number, last)
// config    | psel & penable & pwrite (pready=1) | pwdata[3:0] -> sector_side
//
// A beat that does not close its sector is only stored. The closing beat starts parent
// init over T (cells in use) cells, then per cell and edge: an edge off the sector just
// advances, unequal labels are read and compared, and a join also runs both find chases
// and links the roots; then each cell emits its zone; the parent store's one read port sets the pace.
// Reset clears the controller, load count and zone counter; stores need no clearing.
// Results cannot be held off; busy falls in the cycle that carries the last zone beat.
`include "sector_connected_component_labeler_unit_defines.svh"

module sector_connected_component_labeler_unit #(
	parameter int MAX_SIDE = scclu_pkg::MAX_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	input  scclu_pkg::item_t   item,
	output logic               busy,
	output logic               result_strobe,
	output scclu_pkg::result_t result
);

	localparam int DW = scclu_pkg::DIM_W;

	logic [DW-1:0]      side_q;
	logic               cfg_we;
	scclu_pkg::op_t     op;
	scclu_pkg::status_t status;

	// config register
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready
		&& (paddr[2] == scclu_pkg::REG_SECTOR_SIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= DW'(scclu_pkg::SIDE_RESET);
		end else if (cfg_we) begin
			side_q <= pwdata[DW-1:0];
		end
	end

	assign prdata = (paddr[2] == scclu_pkg::REG_SECTOR_SIDE) ? {{(32-DW){1'b0}}, side_q} : '0;

	scclu_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.busy  (busy),
		.op    (op)
	);

	scclu_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.item         (item),
		.side_cfg     (side_q),
		.status       (status),
		.result       (result),
		.result_strobe(result_strobe)
	);

	// a closing beat must lock out further cells
	`SCCLU_ASSERT_NXT(a_close_busy, start && !busy && status.closes, busy, "closing beat did not raise busy")
	// zone beats come only out of a busy run
	`SCCLU_ASSERT_IMP(a_strobe_busy, result_strobe, $past(busy), "zone beat without a busy run")
	// the sector's final zone beat ends the run, earlier ones do not
	`SCCLU_ASSERT_IMP(a_last_idle, result_strobe && result.last_of_sector, !busy, "busy after last zone beat")
	`SCCLU_ASSERT_IMP(a_mid_busy, result_strobe && !result.last_of_sector, busy, "run ended before last zone beat")

endmodule
